// ===== src/tcgs_pkg.sv =====
package tcgs_pkg;

  localparam int WEIGHT_W = 41;
  localparam int CHAN_W = 16;
  localparam int LEVEL_W = 33;
  localparam int STAGES = 6;
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  localparam logic [63:0] WEIGHT_LIMIT = 64'd1099511627775;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 33'h1_0000_0000;

  typedef enum logic [2:0] {
    REG_ROW_ZERO      = 3'd0,
    REG_ROW_ONE       = 3'd1,
    REG_OFFSETS       = 3'd2,
    REG_FIRST_COLOR   = 3'd3,
    REG_SECOND_COLOR  = 3'd4,
    REG_THIRD_COLOR   = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic lead;
    logic trail;
  } step_en_t;

endpackage

// ===== src/tcgs_weight.sv =====
module tcgs_weight #(
  parameter int COORD_BITS = 14
) (
  input  logic                                   clk,
  input  tcgs_pkg::step_en_t                     en,
  input  logic [COORD_BITS-1:0]                  pixel_x,
  input  logic [COORD_BITS-1:0]                  pixel_y,
  input  logic [63:0]                            row_zero,
  input  logic [63:0]                            row_one,
  input  logic [63:0]                            offsets,
  output logic signed [tcgs_pkg::WEIGHT_W-1:0]   tx,
  output logic signed [tcgs_pkg::WEIGHT_W-1:0]   ty
);

  localparam int PXW = COORD_BITS + 1;
  localparam int PW = PXW + 33;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] W_MAX = $signed(SW'(tcgs_pkg::WEIGHT_LIMIT));
  localparam logic signed [SW-1:0] W_MIN = -W_MAX;

  logic [PXW-1:0]           px;
  logic [PXW-1:0]           py;
  logic signed [PW-1:0]     pa;
  logic signed [PW-1:0]     pb;
  logic signed [PW-1:0]     pd;
  logic signed [PW-1:0]     pe;
  logic signed [32:0]       cx;
  logic signed [32:0]       cy;
  logic signed [SW-1:0]     sum_x;
  logic signed [SW-1:0]     sum_y;

  // pixel center in half-pixel units
  assign px = {pixel_x, 1'b1};
  assign py = {pixel_y, 1'b1};
  assign cx = $signed({offsets[31:0], 1'b0});
  assign cy = $signed({offsets[63:32], 1'b0});

  always_ff @(posedge clk) begin
    if (en.lead) begin
      pa <= $signed(row_zero[31:0]) * $signed({1'b0, px});
      pb <= $signed(row_zero[63:32]) * $signed({1'b0, py});
      pd <= $signed(row_one[31:0]) * $signed({1'b0, px});
      pe <= $signed(row_one[63:32]) * $signed({1'b0, py});
    end
  end

  assign sum_x = SW'(pa) + SW'(pb) + SW'(cx);
  assign sum_y = SW'(pd) + SW'(pe) + SW'(cy);

  always_ff @(posedge clk) begin
    if (en.trail) begin
      if (sum_x > W_MAX) begin
        tx <= tcgs_pkg::WEIGHT_W'(W_MAX);
      end else if (sum_x < W_MIN) begin
        tx <= tcgs_pkg::WEIGHT_W'(W_MIN);
      end else begin
        tx <= tcgs_pkg::WEIGHT_W'(sum_x);
      end
      if (sum_y > W_MAX) begin
        ty <= tcgs_pkg::WEIGHT_W'(W_MAX);
      end else if (sum_y < W_MIN) begin
        ty <= tcgs_pkg::WEIGHT_W'(W_MIN);
      end else begin
        ty <= tcgs_pkg::WEIGHT_W'(sum_y);
      end
    end
  end

endmodule

// ===== src/tcgs_blend.sv =====
module tcgs_blend (
  input  logic                                  clk,
  input  tcgs_pkg::step_en_t                    en,
  input  logic signed [tcgs_pkg::WEIGHT_W-1:0]  tx,
  input  logic signed [tcgs_pkg::WEIGHT_W-1:0]  ty,
  input  logic [tcgs_pkg::CHAN_W-1:0]           c0,
  input  logic [tcgs_pkg::CHAN_W-1:0]           c1,
  input  logic [tcgs_pkg::CHAN_W-1:0]           c2,
  output logic [tcgs_pkg::LEVEL_W-1:0]          level
);

  localparam int DW = tcgs_pkg::CHAN_W + 1;
  localparam int PW = tcgs_pkg::WEIGHT_W + DW;
  localparam int VW = PW + 2;
  localparam logic signed [VW-1:0] V_ONE = $signed(VW'(tcgs_pkg::LEVEL_ONE));

  logic signed [DW-1:0]  d1;
  logic signed [DW-1:0]  d2;
  logic signed [PW-1:0]  p1;
  logic signed [PW-1:0]  p2;
  logic signed [VW-1:0]  base;
  logic signed [VW-1:0]  v;

  assign d1 = $signed({1'b0, c1}) - $signed({1'b0, c0});
  assign d2 = $signed({1'b0, c2}) - $signed({1'b0, c0});

  always_ff @(posedge clk) begin
    if (en.lead) begin
      p1 <= tx * d1;
      p2 <= ty * d2;
    end
  end

  assign base = $signed(VW'({c0, 17'd0}));
  assign v = base + VW'(p1) + VW'(p2);

  always_ff @(posedge clk) begin
    if (en.trail) begin
      if (v < 0) begin
        level <= '0;
      end else if (v > V_ONE) begin
        level <= tcgs_pkg::LEVEL_ONE;
      end else begin
        level <= v[tcgs_pkg::LEVEL_W-1:0];
      end
    end
  end

endmodule

// ===== src/tcgs_premul.sv =====
module tcgs_premul (
  input  logic                          clk,
  input  tcgs_pkg::step_en_t            en,
  input  logic [tcgs_pkg::LEVEL_W-1:0]  a_level,
  input  logic [tcgs_pkg::LEVEL_W-1:0]  r_level,
  input  logic [tcgs_pkg::LEVEL_W-1:0]  g_level,
  input  logic [tcgs_pkg::LEVEL_W-1:0]  b_level,
  output logic [7:0]                    alpha_out,
  output logic [7:0]                    red_out,
  output logic [7:0]                    green_out,
  output logic [7:0]                    blue_out
);

  localparam int LW = tcgs_pkg::LEVEL_W;
  localparam int PW = 2 * LW;
  localparam int SW = PW + 8;
  localparam int AW = LW + 8;

  logic [PW-1:0]  pr;
  logic [PW-1:0]  pg;
  logic [PW-1:0]  pb;
  logic [AW-1:0]  a_scaled;
  logic [7:0]     alpha_mid;
  logic [SW-1:0]  sr;
  logic [SW-1:0]  sg;
  logic [SW-1:0]  sb;

  // round(a * 255) with a in q.32
  assign a_scaled = {a_level, 8'd0} - AW'(a_level) + AW'(33'h0_8000_0000);

  always_ff @(posedge clk) begin
    if (en.lead) begin
      pr <= PW'(r_level) * PW'(a_level);
      pg <= PW'(g_level) * PW'(a_level);
      pb <= PW'(b_level) * PW'(a_level);
      alpha_mid <= a_scaled[39:32];
    end
  end

  // round(x * a * 255) with x * a in q.64
  assign sr = {pr, 8'd0} - SW'(pr) + SW'(64'h8000_0000_0000_0000);
  assign sg = {pg, 8'd0} - SW'(pg) + SW'(64'h8000_0000_0000_0000);
  assign sb = {pb, 8'd0} - SW'(pb) + SW'(64'h8000_0000_0000_0000);

  always_ff @(posedge clk) begin
    if (en.trail) begin
      alpha_out <= alpha_mid;
      red_out <= sr[71:64];
      green_out <= sg[71:64];
      blue_out <= sb[71:64];
    end
  end

endmodule

// ===== src/triangle_color_gradient_shader_core.sv =====
// each request passes through the weight, blend and premultiply units in that order before its
// result appears on the outputs
// throughput: one pixel per cycle unless stalled; each of the six stages advances whenever the next one
// has room, so empty stages fill while the output is stalled
// reset: clears all configuration registers to zero and empties the pipeline
module triangle_color_gradient_shader_core #(
  parameter int COORD_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [5:0]              paddr,
  input  logic [63:0]             pwdata,
  output logic [63:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [COORD_BITS-1:0]   pixel_x,
  input  logic [COORD_BITS-1:0]   pixel_y,
  input  logic                    row_end_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              alpha_out,
  output logic [7:0]              red_out,
  output logic [7:0]              green_out,
  output logic [7:0]              blue_out,
  output logic                    row_end_out
);

  localparam int NS = tcgs_pkg::STAGES;

  logic [63:0]  row_zero;
  logic [63:0]  row_one;
  logic [63:0]  offsets;
  logic [63:0]  color_first;
  logic [63:0]  color_second;
  logic [63:0]  color_third;

  logic [NS-1:0]  valid;
  logic [NS-1:0]  en;
  logic [NS-1:0]  row_end;

  logic signed [tcgs_pkg::WEIGHT_W-1:0]  tx;
  logic signed [tcgs_pkg::WEIGHT_W-1:0]  ty;
  logic [tcgs_pkg::LEVEL_W-1:0]          level [4];

  tcgs_pkg::step_en_t  weight_en;
  tcgs_pkg::step_en_t  blend_en;
  tcgs_pkg::step_en_t  premul_en;

  tcgs_pkg::reg_index_t  wr_index;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign wr_index = tcgs_pkg::reg_index_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_zero <= '0;
      row_one <= '0;
      offsets <= '0;
      color_first <= '0;
      color_second <= '0;
      color_third <= '0;
    end else if (wr_en) begin
      case (wr_index)
        tcgs_pkg::REG_ROW_ZERO:     row_zero <= pwdata;
        tcgs_pkg::REG_ROW_ONE:      row_one <= pwdata;
        tcgs_pkg::REG_OFFSETS:      offsets <= pwdata;
        tcgs_pkg::REG_FIRST_COLOR:  color_first <= pwdata;
        tcgs_pkg::REG_SECOND_COLOR: color_second <= pwdata;
        tcgs_pkg::REG_THIRD_COLOR:  color_third <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_index)
      tcgs_pkg::REG_ROW_ZERO:     prdata = row_zero;
      tcgs_pkg::REG_ROW_ONE:      prdata = row_one;
      tcgs_pkg::REG_OFFSETS:      prdata = offsets;
      tcgs_pkg::REG_FIRST_COLOR:  prdata = color_first;
      tcgs_pkg::REG_SECOND_COLOR: prdata = color_second;
      tcgs_pkg::REG_THIRD_COLOR:  prdata = color_third;
      default:                    prdata = '0;
    endcase
  end

  // a stage loads when it is empty or the next one moves on
  always_comb begin
    en[NS-1] = !valid[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];
  assign out_valid = valid[NS-1];
  assign row_end_out = row_end[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      row_end[0] <= row_end_in;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        row_end[k] <= row_end[k-1];
      end
    end
  end

  assign weight_en = '{lead: en[0], trail: en[1]};
  assign blend_en = '{lead: en[2], trail: en[3]};
  assign premul_en = '{lead: en[4], trail: en[5]};

  tcgs_weight #(
    .COORD_BITS(COORD_BITS)
  ) u_weight (
    .clk      (clk),
    .en       (weight_en),
    .pixel_x  (pixel_x),
    .pixel_y  (pixel_y),
    .row_zero (row_zero),
    .row_one  (row_one),
    .offsets  (offsets),
    .tx       (tx),
    .ty       (ty)
  );

  // channel 0 is blue, 3 is alpha
  for (genvar ch = 0; ch < 4; ch++) begin : g_chan
    tcgs_blend u_blend (
      .clk   (clk),
      .en    (blend_en),
      .tx    (tx),
      .ty    (ty),
      .c0    (color_first[ch*16 +: 16]),
      .c1    (color_second[ch*16 +: 16]),
      .c2    (color_third[ch*16 +: 16]),
      .level (level[ch])
    );
  end

  tcgs_premul u_premul (
    .clk       (clk),
    .en        (premul_en),
    .a_level   (level[3]),
    .r_level   (level[2]),
    .g_level   (level[1]),
    .b_level   (level[0]),
    .alpha_out (alpha_out),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
  );

endmodule
